/* hw/rtl/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the delimiter segment splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

   // default sizing
   localparam int              DEF_MAX_DELIM  = 4;
   localparam longint unsigned DEF_MAX_BUFFER = 64'd65536;

   // delimiter register holds this many bytes; bytes above it read as zero
   localparam int DELIM_REG_BYTES = 4;

   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 16;
   localparam int LENGTH_W = 17;
   localparam int DLEN_W   = 3;
   localparam int CSR_W    = 32;

   // register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_DELIM_BYTES = 1'b0,
      CSR_DELIM_LEN   = 1'b1
   } csr_index_type;

   localparam logic [CSR_W-1:0]  DELIM_BYTES_RST = 32'h0000_0A0D;
   localparam logic [DLEN_W-1:0] DELIM_LEN_RST   = 3'd2;

   // one result request
   typedef struct packed {
      logic [OFFSET_W-1:0] segment_offset;
      logic [LENGTH_W-1:0] segment_length;
      logic                final_segment;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/delimiter_segment_splitter_top.sv */
// ----------------------------------------------------------------------------
// delimiter_segment_splitter_top
// Splits a byte stream at occurrences of a configurable 1..N byte delimiter.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one buffer byte per request, req_last_byte on the final byte.
//  - rsp_*: one request per segment: offset, length (delimiter included) and
//    final_segment on the last segment of the buffer.
//  - csr_*: register writes (delim_bytes, delim_len); csr_ready is always
//    high. Write only while the block is idle.
//  - Throughput: one byte per cycle while req_stall is low, set by the
//    combinational window compare between handshake and result register.
//  - Output: the result of the byte that ends a segment is registered
//    into the output register, or the skid register if rsp_* stalls.
//  - Stall: a result held by rsp_stall stays in the output register; one more
//    result fits in a skid register, after which req_stall goes high until
//    the output drains. Bytes that produce no result flow until the skid fills.
//  - Reset: delimiter returns to CR LF (length 2), byte window, position and
//    segment start clear, both output registers empty.
//  - Bytes past MAX_BUFFER are dropped; a last flag on them still closes the
//    buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_segment_splitter_top #(
   parameter int              MAX_DELIM  = dss_pkg::DEF_MAX_DELIM,
   parameter longint unsigned MAX_BUFFER = dss_pkg::DEF_MAX_BUFFER
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // byte requests
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [dss_pkg::DATA_W-1:0]    req_data_byte,
   input  wire logic                          req_last_byte,
   // segment results
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [dss_pkg::OFFSET_W-1:0]  rsp_segment_offset,
   output      logic [dss_pkg::LENGTH_W-1:0]  rsp_segment_length,
   output      logic                          rsp_final_segment,
   // configuration
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [dss_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int POS_W  = $clog2(MAX_BUFFER + 64'd1);
   localparam int LEN_W  = $clog2(MAX_DELIM + 1);
   localparam int DIDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
   localparam int WIN_D  = (MAX_DELIM > 1) ? MAX_DELIM - 1 : 1;
   localparam logic [POS_W-1:0] BUF_LIMIT = POS_W'(MAX_BUFFER);

   // ---------------------------------------------------------------- config
   logic [dss_pkg::CSR_W-1:0]  delim_bytes_ff;
   logic [dss_pkg::DLEN_W-1:0] delim_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff <= dss_pkg::DELIM_BYTES_RST;
         delim_len_ff   <= dss_pkg::DELIM_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (dss_pkg::csr_index_type'(csr_index))
            dss_pkg::CSR_DELIM_BYTES: delim_bytes_ff <= csr_wdata;
            dss_pkg::CSR_DELIM_LEN:   delim_len_ff   <= csr_wdata[dss_pkg::DLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // active delimiter length, clamped to 1..MAX_DELIM
   logic [LEN_W-1:0] alen;
   always_comb begin
      if (delim_len_ff == '0) begin
         alen = LEN_W'(1);
      end else if (int'(delim_len_ff) > MAX_DELIM) begin
         alen = LEN_W'(MAX_DELIM);
      end else begin
         alen = LEN_W'(delim_len_ff);
      end
   end

   // delimiter bytes as an array; unused upper bytes are zero
   logic [dss_pkg::DATA_W-1:0] delim_b [MAX_DELIM];
   always_comb begin
      for (int k = 0; k < MAX_DELIM; k++) begin
         if (k < dss_pkg::DELIM_REG_BYTES) begin
            delim_b[k] = delim_bytes_ff[8*k +: 8];
         end else begin
            delim_b[k] = '0;
         end
      end
   end

   // ---------------------------------------------------------------- state
   logic [dss_pkg::DATA_W-1:0] window_ff [WIN_D];   // most recent first
   logic [dss_pkg::DATA_W-1:0] window_in [WIN_D];
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [POS_W-1:0]           seg_ff, seg_in;

   logic                       accept;
   logic                       active;      // below the buffer limit
   logic                       in_reach;    // whole delimiter after seg start
   logic                       match;
   logic [POS_W-1:0]           pos_step;    // position after this byte
   logic                       has_result;
   dss_pkg::result_type        result;

   logic                       skid_valid_ff;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign active    = (pos_ff < BUF_LIMIT);
   assign pos_step  = active ? pos_ff + POS_W'(1) : pos_ff;

   assign in_reach = ((POS_W+1)'(pos_ff) + (POS_W+1)'(1))
                     >= ((POS_W+1)'(seg_ff) + (POS_W+1)'(alen));

   // delimiter compare: newest byte against the delimiter's last byte,
   // window entry j-1 against delimiter byte alen-1-j
   always_comb begin
      logic [DIDX_W-1:0] sel;
      match = in_reach;
      for (int j = 0; j < MAX_DELIM; j++) begin
         sel = DIDX_W'(int'(alen) - 1 - j);
         if (j < int'(alen)) begin
            if (j == 0) begin
               if (req_data_byte != delim_b[sel]) match = 1'b0;
            end else begin
               if (window_ff[(j > 0) ? j - 1 : 0] != delim_b[sel]) match = 1'b0;
            end
         end
      end
   end

   // next state
   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      seg_in    = seg_ff;
      if (accept) begin
         if (active) begin
            for (int k = WIN_D - 1; k > 0; k--) begin
               window_in[k] = window_ff[k-1];
            end
            window_in[0] = req_data_byte;
            pos_in       = pos_step;
            if (match) seg_in = pos_step;
         end
         if (req_last_byte) begin
            for (int k = 0; k < WIN_D; k++) window_in[k] = '0;
            pos_in = '0;
            seg_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_D; k++) window_ff[k] <= '0;
         pos_ff <= '0;
         seg_ff <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         seg_ff    <= seg_in;
      end
   end

   // result: a completed match, or the trailing segment on the last byte
   assign has_result = accept && ((active && match) || req_last_byte);
   always_comb begin
      result.segment_offset = dss_pkg::OFFSET_W'(seg_ff);
      result.segment_length = dss_pkg::LENGTH_W'(pos_step - seg_ff);
      result.final_segment  = req_last_byte;
   end

   // ---------------------------------------------------------------- output
   logic                rsp_valid_ff, rsp_valid_in;
   logic                skid_valid_in;
   dss_pkg::result_type rsp_ff, rsp_in;
   dss_pkg::result_type skid_ff, skid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = has_result;
            if (has_result) rsp_in = result;
         end
      end else if (has_result) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_offset = rsp_ff.segment_offset;
   assign rsp_segment_length = rsp_ff.segment_length;
   assign rsp_final_segment  = rsp_ff.final_segment;

   // ---------------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_seg_le_pos: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= pos_ff)
      else $error("segment start ahead of position");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> (pos_ff == '0) && (seg_ff == '0))
      else $error("buffer state not cleared after last byte");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= BUF_LIMIT)
      else $error("position past buffer limit");

endmodule

`default_nettype wire
